@@ hdl/crd_pkg.sv @@
`default_nettype none

package crd_pkg;

    // geometry mode codes
    localparam logic [1:0] GEOM_2D     = 2'd0;
    localparam logic [1:0] GEOM_3D     = 2'd1;
    localparam logic [1:0] GEOM_AXISYM = 2'd2;
    localparam logic [1:0] GEOM_SPARE  = 2'd3;

    // configuration register indexes
    localparam logic [2:0] REG_MODE   = 3'd0;
    localparam logic [2:0] REG_ORG_X  = 3'd1;
    localparam logic [2:0] REG_ORG_Y  = 3'd2;
    localparam logic [2:0] REG_ORG_Z  = 3'd3;
    localparam logic [2:0] REG_AXIS_X = 3'd4;
    localparam logic [2:0] REG_AXIS_Y = 3'd5;
    localparam logic [2:0] REG_AXIS_Z = 3'd6;

    localparam logic signed [15:0] AXIS_Z_RESET = 16'sd16384;

    localparam int AXIS_FRAC   = 14;
    localparam int NORM_LO     = 29;
    localparam int SQRT_STAGES = 16;
    localparam int DIV_STAGES  = 16;
    localparam int PIPE_DEPTH  = 13 + SQRT_STAGES + 3 + DIV_STAGES + 1;

    localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] SAT_MIN = 32'h8000_0000;

    // square root step state
    typedef struct packed {
        logic [63:0] v;
        logic [33:0] rem;
        logic [31:0] root;
    } sq_t;

    // divider step state
    typedef struct packed {
        logic [32:0] n;
        logic [32:0] rem;
        logic [31:0] num;
        logic [31:0] q;
    } dv_t;

    // side data through the root stages
    typedef struct packed {
        logic               zero;
        logic signed [63:0] dot;
        logic signed [31:0] dx;
    } sq_side_t;

    // side data through the divider stages
    typedef struct packed {
        logic               zero;
        logic               neg;
        logic               ovf;
        logic signed [31:0] dx;
    } dv_side_t;

    function automatic sq_t sqrt_step(input sq_t a);
        logic [35:0] rt;
        logic [35:0] trial;
        sq_t         b;
        rt    = {a.rem, a.v[63:62]};
        trial = {2'b00, a.root, 2'b01};
        b.v   = {a.v[61:0], 2'b00};
        if (rt >= trial)
        begin
            b.rem  = 34'(rt - trial);
            b.root = {a.root[30:0], 1'b1};
        end
        else
        begin
            b.rem  = rt[33:0];
            b.root = {a.root[30:0], 1'b0};
        end
        return b;
    endfunction

    function automatic dv_t div_step(input dv_t a);
        logic [33:0] rt;
        dv_t         b;
        rt    = {a.rem, a.num[31]};
        b.n   = a.n;
        b.num = {a.num[30:0], 1'b0};
        if (rt >= {1'b0, a.n})
        begin
            b.rem = 33'(rt - {1'b0, a.n});
            b.q   = {a.q[30:0], 1'b1};
        end
        else
        begin
            b.rem = rt[32:0];
            b.q   = {a.q[30:0], 1'b0};
        end
        return b;
    endfunction

    // position of the leading one, binary search
    function automatic logic [5:0] msb_pos(input logic [53:0] x);
        logic [5:0]  p;
        logic [53:0] y;
        p = 6'd0;
        y = x;
        if (y[53:32] != 22'd0)
        begin
            p[5] = 1'b1;
            y    = y >> 32;
        end
        if (y[31:16] != 16'd0)
        begin
            p[4] = 1'b1;
            y    = y >> 16;
        end
        if (y[15:8] != 8'd0)
        begin
            p[3] = 1'b1;
            y    = y >> 8;
        end
        if (y[7:4] != 4'd0)
        begin
            p[2] = 1'b1;
            y    = y >> 4;
        end
        if (y[3:2] != 2'd0)
        begin
            p[1] = 1'b1;
            y    = y >> 2;
        end
        if (y[1])
        begin
            p[0] = 1'b1;
        end
        return p;
    endfunction

endpackage

`default_nettype wire

@@ hdl/cylinder_radial_displacement_core.sv @@
`default_nettype none

// radial displacement of mesh nodes about a cylinder axis
//
// input channel: an item (point_x/y/z, disp_x/y/z) transfers at a rising edge
// with start high and busy low; busy is held low, so an item may transfer on
// every clock edge
// result channel: done is high for exactly one cycle per item with
// radial_disp and on_axis valid in that cycle; the receiver cannot stall, so
// the pipeline never holds and results leave in input order
// pipeline: throughput is one item per cycle, set by the fixed 49-stage
// pipeline (13 geometry and multiply stages, a 16-stage square root unit
// at two root bits per stage, 3 setup stages, a 16-stage divider at two
// quotient bits per stage and the output stage)
// configuration: cfg_valid/cfg_ready write channel, cfg_index selects the register
// (mode, origin x/y/z, axis x/y/z), cfg_data carries the value; cfg_ready is always
// high; the user must write only while no item is in flight, the block does not enforce it
// reset: rst_n clears the pipeline valid line and loads the register reset
// values (2D mode, origin zero, axis along +z); no result is produced for
// items in flight at reset
module cylinder_radial_displacement_core
    import crd_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [31:0] point_x,
    input  wire logic signed [31:0] point_y,
    input  wire logic signed [31:0] point_z,
    input  wire logic signed [31:0] disp_x,
    input  wire logic signed [31:0] disp_y,
    input  wire logic signed [31:0] disp_z,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [31:0]        cfg_data,
    output logic                    done,
    output logic signed [31:0]      radial_disp,
    output logic                    on_axis
);

    // configuration registers
    logic [1:0]         mode_reg;
    logic signed [31:0] org_reg  [3];
    logic signed [15:0] axis_reg [3];

    logic is_2d;
    logic is_3d;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign is_2d     = (mode_reg == GEOM_2D);
    assign is_3d     = (mode_reg == GEOM_3D);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= GEOM_2D;
            org_reg[0]  <= '0;
            org_reg[1]  <= '0;
            org_reg[2]  <= '0;
            axis_reg[0] <= '0;
            axis_reg[1] <= '0;
            axis_reg[2] <= AXIS_Z_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_MODE:   mode_reg    <= cfg_data[1:0];
                REG_ORG_X:  org_reg[0]  <= cfg_data;
                REG_ORG_Y:  org_reg[1]  <= cfg_data;
                REG_ORG_Z:  org_reg[2]  <= cfg_data;
                REG_AXIS_X: axis_reg[0] <= cfg_data[15:0];
                REG_AXIS_Y: axis_reg[1] <= cfg_data[15:0];
                REG_AXIS_Z: axis_reg[2] <= cfg_data[15:0];
                default:    ;
            endcase
        end
    end

    // valid line, one bit per stage; nothing ever stalls
    logic [PIPE_DEPTH-1:0] vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[PIPE_DEPTH-2:0], start & ~busy};
        end
    end

    assign done = vld_reg[PIPE_DEPTH-1];

    // stage A: input capture; u travels down a delay line
    logic signed [31:0] p_a_reg   [3];
    logic signed [31:0] u_dly_reg [10][3];
    // stage B..G: d = p - o travels down its own delay line
    logic signed [32:0] d_dly_reg [1:6][3];
    logic signed [48:0] c_prod_reg [3];
    logic signed [50:0] d_traw_reg;
    logic [36:0]        e_tmag_reg;
    logic               e_tneg_reg;
    logic signed [37:0] f_t_reg;
    logic signed [53:0] g_ta_reg [3];
    logic signed [54:0] h_r_reg  [3];
    logic [53:0]        i_m_reg  [3];
    logic [2:0]         i_neg_reg;
    logic [53:0]        i_or_reg;
    logic [53:0]        j_m_reg  [3];
    logic [2:0]         j_neg_reg;
    logic [5:0]         j_pos_reg;
    logic               j_zero_reg;
    logic [29:0]        k_mn_reg [3];
    logic [31:0]        k_um_reg [3];
    logic signed [31:0] k_u_reg  [3];
    logic [2:0]         k_neg_reg;
    logic               k_zero_reg;
    logic [63:0]        l_sqp_reg [3];
    logic signed [62:0] l_dotp_reg [3];
    logic [2:0]         l_neg_reg;
    logic               l_zero_reg;
    logic signed [31:0] l_dx_reg;
    logic [63:0]        m_sum_reg;
    logic signed [63:0] m_dot_reg;
    logic               m_zero_reg;
    logic signed [31:0] m_dx_reg;

    // combinational next values of the geometry stages
    logic [50:0]        traw_mag;
    logic [53:0]        k_shr  [3];
    logic [53:0]        k_shl  [3];
    logic [29:0]        mn_next [3];
    logic signed [31:0] uk_next [3];
    logic [31:0]        op_next [3];
    logic signed [63:0] dot_term [3];

    always_comb
    begin
        traw_mag = d_traw_reg[50] ? 51'(-d_traw_reg) : 51'(d_traw_reg);
        for (int i = 0; i < 3; i++)
        begin
            // scale so the largest magnitude sits in [2^29, 2^30)
            k_shr[i] = j_m_reg[i] >> (j_pos_reg - 6'(NORM_LO));
            k_shl[i] = j_m_reg[i] << (6'(NORM_LO) - j_pos_reg);
            if (j_pos_reg >= 6'(NORM_LO))
            begin
                mn_next[i] = k_shr[i][29:0];
            end
            else
            begin
                mn_next[i] = k_shl[i][29:0];
            end
            uk_next[i] = u_dly_reg[9][i];
            op_next[i] = k_zero_reg ? k_um_reg[i] : {2'b00, k_mn_reg[i]};
            dot_term[i] = l_neg_reg[i] ? -64'(l_dotp_reg[i]) : 64'(l_dotp_reg[i]);
        end
        // the z displacement does not count in 2D
        if (is_2d)
        begin
            uk_next[2] = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        // A
        p_a_reg[0]      <= point_x;
        p_a_reg[1]      <= point_y;
        p_a_reg[2]      <= point_z;
        u_dly_reg[0][0] <= disp_x;
        u_dly_reg[0][1] <= disp_y;
        u_dly_reg[0][2] <= disp_z;
        for (int k = 1; k < 10; k++)
        begin
            u_dly_reg[k] <= u_dly_reg[k-1];
        end
        // B: offset from the origin
        for (int i = 0; i < 3; i++)
        begin
            d_dly_reg[1][i] <= 33'(p_a_reg[i]) - 33'(org_reg[i]);
        end
        for (int k = 2; k < 7; k++)
        begin
            d_dly_reg[k] <= d_dly_reg[k-1];
        end
        // C: projection products
        for (int i = 0; i < 3; i++)
        begin
            c_prod_reg[i] <= 49'(d_dly_reg[1][i]) * 49'(axis_reg[i]);
        end
        // D
        d_traw_reg <= 51'(c_prod_reg[0]) + 51'(c_prod_reg[1]) + 51'(c_prod_reg[2]);
        // E: round half away from zero
        e_tmag_reg <= 37'((traw_mag + (51'(1) << (AXIS_FRAC - 1))) >> AXIS_FRAC);
        e_tneg_reg <= d_traw_reg[50];
        // F
        f_t_reg <= e_tneg_reg ? -signed'({1'b0, e_tmag_reg}) : signed'({1'b0, e_tmag_reg});
        // G
        for (int i = 0; i < 3; i++)
        begin
            g_ta_reg[i] <= 54'(f_t_reg) * 54'(axis_reg[i]);
        end
        // H: radius vector, no z part outside 3D
        for (int i = 0; i < 3; i++)
        begin
            if (is_3d)
            begin
                h_r_reg[i] <= (55'(d_dly_reg[6][i]) <<< AXIS_FRAC) - 55'(g_ta_reg[i]);
            end
            else if (i < 2)
            begin
                h_r_reg[i] <= 55'(d_dly_reg[6][i]);
            end
            else
            begin
                h_r_reg[i] <= '0;
            end
        end
        // I: magnitudes
        for (int i = 0; i < 3; i++)
        begin
            i_neg_reg[i] <= h_r_reg[i][54];
            i_m_reg[i]   <= h_r_reg[i][54] ? 54'(-h_r_reg[i]) : 54'(h_r_reg[i]);
        end
        i_or_reg <= (h_r_reg[0][54] ? 54'(-h_r_reg[0]) : 54'(h_r_reg[0]))
                  | (h_r_reg[1][54] ? 54'(-h_r_reg[1]) : 54'(h_r_reg[1]))
                  | (h_r_reg[2][54] ? 54'(-h_r_reg[2]) : 54'(h_r_reg[2]));
        // J: leading one
        j_m_reg    <= i_m_reg;
        j_neg_reg  <= i_neg_reg;
        j_pos_reg  <= msb_pos(i_or_reg);
        j_zero_reg <= (i_or_reg == '0);
        // K: normalize
        for (int i = 0; i < 3; i++)
        begin
            k_mn_reg[i] <= mn_next[i];
            k_u_reg[i]  <= uk_next[i];
            k_um_reg[i] <= uk_next[i][31] ? 32'(-uk_next[i]) : 32'(uk_next[i]);
        end
        k_neg_reg  <= j_neg_reg;
        k_zero_reg <= j_zero_reg;
        // L: squares and dot products
        for (int i = 0; i < 3; i++)
        begin
            l_sqp_reg[i]  <= 64'(op_next[i]) * 64'(op_next[i]);
            l_dotp_reg[i] <= 63'(signed'({1'b0, k_mn_reg[i]})) * 63'(k_u_reg[i]);
        end
        l_neg_reg  <= k_neg_reg;
        l_zero_reg <= k_zero_reg;
        l_dx_reg   <= k_u_reg[0];
        // M: sums
        m_sum_reg  <= l_sqp_reg[0] + l_sqp_reg[1] + l_sqp_reg[2];
        m_dot_reg  <= dot_term[0] + dot_term[1] + dot_term[2];
        m_zero_reg <= l_zero_reg;
        m_dx_reg   <= l_dx_reg;
    end

    // square root unit, two root bits per stage
    sq_t      sq_reg      [SQRT_STAGES];
    sq_side_t sq_side_reg [SQRT_STAGES];
    sq_t      sq_in;
    sq_side_t sq_side_in;

    assign sq_in      = '{v: m_sum_reg, rem: '0, root: '0};
    assign sq_side_in = '{zero: m_zero_reg, dot: m_dot_reg, dx: m_dx_reg};

    for (genvar s = 0; s < SQRT_STAGES; s++)
    begin : g_sqrt
        sq_t      sq_next;
        sq_side_t side_next;
        assign sq_next   = sqrt_step(sqrt_step(s == 0 ? sq_in : sq_reg[(s == 0) ? 0 : s-1]));
        assign side_next = (s == 0) ? sq_side_in : sq_side_reg[(s == 0) ? 0 : s-1];
        always_ff @(posedge clk)
        begin
            sq_reg[s]      <= sq_next;
            sq_side_reg[s] <= side_next;
        end
    end

    // P: rounded root and dot magnitude; Q: rounded numerator; R: divider setup
    logic [32:0]        p_n_reg;
    logic [62:0]        p_dm_reg;
    logic               p_neg_reg;
    logic               p_zero_reg;
    logic signed [31:0] p_dx_reg;
    logic [32:0]        q_n_reg;
    logic [63:0]        q_num_reg;
    logic               q_neg_reg;
    logic               q_zero_reg;
    logic signed [31:0] q_dx_reg;
    dv_t                r_dv_reg;
    dv_side_t           r_side_reg;
    sq_t                sq_last;
    sq_side_t           sq_side_last;

    assign sq_last      = sq_reg[SQRT_STAGES-1];
    assign sq_side_last = sq_side_reg[SQRT_STAGES-1];

    always_ff @(posedge clk)
    begin
        p_n_reg    <= 33'(sq_last.root) + 33'(sq_last.rem > {2'b00, sq_last.root});
        p_dm_reg   <= sq_side_last.dot[63] ? 63'(-sq_side_last.dot) : 63'(sq_side_last.dot);
        p_neg_reg  <= sq_side_last.dot[63];
        p_zero_reg <= sq_side_last.zero;
        p_dx_reg   <= sq_side_last.dx;

        q_n_reg    <= p_n_reg;
        q_num_reg  <= 64'(p_dm_reg) + 64'(p_n_reg >> 1);
        q_neg_reg  <= p_neg_reg;
        q_zero_reg <= p_zero_reg;
        q_dx_reg   <= p_dx_reg;

        r_dv_reg.n   <= q_n_reg;
        r_dv_reg.rem <= 33'(q_num_reg[63:32]);
        r_dv_reg.num <= q_num_reg[31:0];
        r_dv_reg.q   <= '0;
        r_side_reg   <= '{zero: q_zero_reg, neg: q_neg_reg,
                          ovf: (33'(q_num_reg[63:32]) >= q_n_reg), dx: q_dx_reg};
    end

    // divider, two quotient bits per stage
    dv_t      dv_reg      [DIV_STAGES];
    dv_side_t dv_side_reg [DIV_STAGES];

    for (genvar s = 0; s < DIV_STAGES; s++)
    begin : g_div
        dv_t      dv_next;
        dv_side_t side_next;
        assign dv_next   = div_step(div_step(s == 0 ? r_dv_reg : dv_reg[(s == 0) ? 0 : s-1]));
        assign side_next = (s == 0) ? r_side_reg : dv_side_reg[(s == 0) ? 0 : s-1];
        always_ff @(posedge clk)
        begin
            dv_reg[s]      <= dv_next;
            dv_side_reg[s] <= side_next;
        end
    end

    // output stage: mode select and saturation
    dv_t                dv_last;
    dv_side_t           side_last;
    logic signed [31:0] radial_disp_next;
    logic               on_axis_next;

    assign dv_last   = dv_reg[DIV_STAGES-1];
    assign side_last = dv_side_reg[DIV_STAGES-1];

    always_comb
    begin
        on_axis_next = 1'b0;
        if (!is_2d && !is_3d)
        begin
            // axisymmetric or spare mode: first displacement component
            radial_disp_next = side_last.dx;
        end
        else if (side_last.zero)
        begin
            // on the axis: displacement length
            on_axis_next = 1'b1;
            if (dv_last.n > 33'(SAT_MAX))
            begin
                radial_disp_next = SAT_MAX;
            end
            else
            begin
                radial_disp_next = dv_last.n[31:0];
            end
        end
        else if (!side_last.neg)
        begin
            if (side_last.ovf || dv_last.q[31])
            begin
                radial_disp_next = SAT_MAX;
            end
            else
            begin
                radial_disp_next = dv_last.q;
            end
        end
        else
        begin
            if (side_last.ovf || (dv_last.q > SAT_MIN))
            begin
                radial_disp_next = SAT_MIN;
            end
            else
            begin
                radial_disp_next = 32'(-dv_last.q);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        radial_disp <= radial_disp_next;
        on_axis     <= on_axis_next;
    end

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
`default_nettype none

module tb_top;
    import crd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // expected result of one item
    typedef struct {
        logic signed [31:0] radial;
        logic               axis_flag;
    } radial_exp_t;

    localparam int SETTLE_CYCLES = PIPE_DEPTH + 10;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic signed [31:0] disp_x;
    logic signed [31:0] disp_y;
    logic signed [31:0] disp_z;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [2:0]         cfg_index;
    logic [31:0]        cfg_data;
    logic               done;
    logic signed [31:0] radial_disp;
    logic               on_axis;

    // shadow copy of the block's registers
    logic [1:0]         geom_mode;
    longint             org [3];
    longint             axis_dir [3];

    radial_exp_t        radial_q [$];
    int                 mismatches;
    int                 idle_pct;

    cylinder_radial_displacement_core u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .point_x     (point_x),
        .point_y     (point_y),
        .point_z     (point_z),
        .disp_x      (disp_x),
        .disp_y      (disp_y),
        .disp_z      (disp_z),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .done        (done),
        .radial_disp (radial_disp),
        .on_axis     (on_axis)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // generous run limit
    initial
    begin
        #5ms;
        $display("TEST FAILED");
        $finish;
    end

    // rounded integer square root, nearest
    function automatic longint unsigned root_nearest(input longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
            begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        if (v > res)
            res = res + 1;
        return res;
    endfunction

    function automatic longint unsigned magnitude(input longint v);
        return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    // radial component of the displacement for the current register set
    function automatic radial_exp_t radial_component(
        input logic signed [31:0] px, input logic signed [31:0] py,
        input logic signed [31:0] pz, input logic signed [31:0] ux,
        input logic signed [31:0] uy, input logic signed [31:0] uz);
        longint          p [3];
        longint          u [3];
        longint          r [3];
        longint          d [3];
        longint unsigned m [3];
        bit              neg [3];
        longint unsigned mx;
        longint unsigned sq;
        longint unsigned n;
        longint unsigned q;
        longint          traw;
        longint          t;
        longint          dot;
        longint          res;
        radial_exp_t     e;
        p[0] = px; p[1] = py; p[2] = pz;
        u[0] = ux; u[1] = uy; u[2] = uz;
        e.axis_flag = 1'b0;
        if (geom_mode != GEOM_2D && geom_mode != GEOM_3D)
        begin
            e.radial = ux;
            return e;
        end
        if (geom_mode == GEOM_2D)
        begin
            r[0] = p[0] - org[0];
            r[1] = p[1] - org[1];
            r[2] = 0;
            u[2] = 0;
        end
        else
        begin
            traw = 0;
            for (int i = 0; i < 3; i++)
            begin
                d[i] = p[i] - org[i];
                traw += d[i] * axis_dir[i];
            end
            // round half away from zero
            t = longint'((magnitude(traw) + (64'd1 << (AXIS_FRAC - 1))) >> AXIS_FRAC);
            if (traw < 0)
                t = -t;
            for (int i = 0; i < 3; i++)
                r[i] = d[i] * (64'sd1 <<< AXIS_FRAC) - t * axis_dir[i];
        end
        mx = 0;
        for (int i = 0; i < 3; i++)
        begin
            neg[i] = r[i] < 0;
            m[i]   = magnitude(r[i]);
            if (m[i] > mx)
                mx = m[i];
        end
        if (mx == 0)
        begin
            // on the axis: length of the displacement
            sq = 0;
            for (int i = 0; i < 3; i++)
                sq += magnitude(u[i]) * magnitude(u[i]);
            q = root_nearest(sq);
            e.radial    = (q > 64'h7FFF_FFFF) ? SAT_MAX : q[31:0];
            e.axis_flag = 1'b1;
            return e;
        end
        while (mx >= (64'd1 << (NORM_LO + 1)))
        begin
            mx = mx >> 1;
            for (int i = 0; i < 3; i++)
                m[i] = m[i] >> 1;
        end
        while (mx < (64'd1 << NORM_LO))
        begin
            mx = mx << 1;
            for (int i = 0; i < 3; i++)
                m[i] = m[i] << 1;
        end
        dot = 0;
        sq  = 0;
        for (int i = 0; i < 3; i++)
        begin
            dot += (neg[i] ? -longint'(m[i]) : longint'(m[i])) * u[i];
            sq  += m[i] * m[i];
        end
        n   = root_nearest(sq);
        q   = (magnitude(dot) + n / 2) / n;
        res = (dot < 0) ? -longint'(q) : longint'(q);
        if (res > 64'sh7FFF_FFFF)
            e.radial = SAT_MAX;
        else if (res < -64'sh8000_0000)
            e.radial = SAT_MIN;
        else
            e.radial = res[31:0];
        return e;
    endfunction

    // result checker: done marks one result per cycle, no stall possible
    always @(posedge clk)
    begin
        radial_exp_t e;
        if (rst_n && done)
        begin
            if (radial_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result radial=%0d on_axis=%0b", radial_disp, on_axis);
            end
            else
            begin
                e = radial_q.pop_front();
                if (radial_disp !== e.radial || on_axis !== e.axis_flag)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp radial=%0d on_axis=%0b, got radial=%0d on_axis=%0b",
                                 e.radial, e.axis_flag, radial_disp, on_axis);
                end
            end
        end
    end

    // one register write transfer
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_MODE:   geom_mode = val[1:0];
            REG_ORG_X:  org[0] = longint'(signed'(val));
            REG_ORG_Y:  org[1] = longint'(signed'(val));
            REG_ORG_Z:  org[2] = longint'(signed'(val));
            REG_AXIS_X: axis_dir[0] = longint'(signed'(val[15:0]));
            REG_AXIS_Y: axis_dir[1] = longint'(signed'(val[15:0]));
            REG_AXIS_Z: axis_dir[2] = longint'(signed'(val[15:0]));
            default:    ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_geometry(input logic [1:0] mode, input int ox, input int oy,
                                input int oz, input int ax, input int ay, input int az);
        write_reg(REG_MODE, {$urandom} & 32'hFFFF_FFFC | mode);
        write_reg(REG_ORG_X, ox);
        write_reg(REG_ORG_Y, oy);
        write_reg(REG_ORG_Z, oz);
        // upper half of the axis words carries junk on purpose
        write_reg(REG_AXIS_X, {16'($urandom), 16'(ax)});
        write_reg(REG_AXIS_Y, {16'($urandom), 16'(ay)});
        write_reg(REG_AXIS_Z, {16'($urandom), 16'(az)});
    endtask

    // one item transfer, with a random idle gap before it
    task automatic send_node(input int px, input int py, input int pz,
                             input int ux, input int uy, input int uz);
        while ($urandom_range(99) < idle_pct)
        begin
            start = 1'b0;
            @(negedge clk);
        end
        start   = 1'b1;
        point_x = px;
        point_y = py;
        point_z = pz;
        disp_x  = ux;
        disp_y  = uy;
        disp_z  = uz;
        do @(posedge clk); while (busy);
        radial_q.push_back(radial_component(px, py, pz, ux, uy, uz));
        @(negedge clk);
        start = 1'b0;
    endtask

    // block idle: every result back, then the pipeline drained
    task automatic drain_results();
        @(negedge clk);
        start = 1'b0;
        while (radial_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    function automatic int rand_coord();
        case ($urandom_range(9))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return 0;
            3:       return $urandom_range(2000) - 1000;
            4, 5:    return int'($urandom) >>> $urandom_range(24);
            default: return $urandom;
        endcase
    endfunction

    task automatic test_directed_2d();
        set_geometry(GEOM_2D, 0, 0, 0, 0, 0, 16384);
        // on the axis: displacement length, extremes saturate
        send_node(0, 0, 123, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
        send_node(0, 0, 0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 5);
        send_node(0, 0, 0, 3 << 16, 4 << 16, 0);
        send_node(0, 0, 0, 0, 0, 0);
        send_node(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0);
        send_node(32'sh8000_0000, 32'sh8000_0000, 0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0);
        send_node(1, 0, 0, 32'sh8000_0000, -1, 32'sh7FFF_FFFF);
        send_node(-1, 1, 0, 1, -1, 7);
        drain_results();
        set_geometry(GEOM_2D, 32'sh7FFF_FFFF, 32'sh8000_0000, 0, 0, 0, 16384);
        send_node(32'sh8000_0000, 32'sh7FFF_FFFF, 0, 100, -100, 0);
        send_node(32'sh7FFF_FFFF, 32'sh8000_0000, 9, 100, -100, 0);
        drain_results();
    endtask

    task automatic test_directed_3d();
        set_geometry(GEOM_3D, 0, 0, 0, 0, 0, 16384);
        send_node(0, 0, 32'sh7FFF_FFFF, 5, 6, 7);
        send_node(1 << 16, 0, 32'sh8000_0000, 1 << 16, 1 << 16, 1 << 16);
        drain_results();
        set_geometry(GEOM_3D, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
                     -16384, 16384, -16384);
        send_node(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
                  32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
        send_node(0, 0, 0, -1, -1, -1);
        drain_results();
        // zero axis is used as given
        set_geometry(GEOM_3D, 10, 20, 30, 0, 0, 0);
        send_node(10, 20, 30, 1, 2, 3);
        send_node(11, 20, 30, 32'sh8000_0000, 0, 0);
        drain_results();
    endtask

    task automatic test_directed_axisym();
        set_geometry(GEOM_AXISYM, 5, 5, 5, 16384, 0, 0);
        send_node(5, 5, 5, 32'sh8000_0000, 1, 1);
        send_node(0, 0, 0, 32'sh7FFF_FFFF, 1, 1);
        drain_results();
        // unused mode code behaves as axisymmetric
        set_geometry(GEOM_SPARE, 0, 0, 0, 0, 0, 16384);
        send_node(0, 0, 0, -42, 9, 9);
        send_node(1, 2, 3, 32'sh8000_0000, 9, 9);
        drain_results();
    endtask

    // random content over a random register set, some nodes forced onto the axis
    task automatic test_random(input int nodes);
        int  ox, oy, oz, ax, ay, az, k;
        int  px, py, pz;
        case ($urandom_range(4))
            0:       begin ax = 16384; ay = 0;      az = 0;      end
            1:       begin ax = 0;     ay = -16384; az = 0;      end
            2:       begin ax = 0;     ay = 0;      az = 16384;  end
            3:       begin ax = 11585; ay = -11585; az = 0;      end
            default: begin ax = int'(16'($urandom)); ay = int'(16'($urandom));
                           az = int'(16'($urandom)); end
        endcase
        ax = 32'(signed'(16'(ax)));
        ay = 32'(signed'(16'(ay)));
        az = 32'(signed'(16'(az)));
        ox = rand_coord();
        oy = rand_coord();
        oz = rand_coord();
        set_geometry(2'($urandom_range(3)), ox, oy, oz, ax, ay, az);
        for (int i = 0; i < nodes; i++)
        begin
            px = rand_coord();
            py = rand_coord();
            pz = rand_coord();
            if ($urandom_range(9) == 0)
            begin
                // on the axis: origin x and y, plus a z offset when the 3D axis lies along z
                k  = $urandom_range(200) - 100;
                px = ox;
                py = oy;
                if (geom_mode == GEOM_3D && ax == 0 && ay == 0)
                    pz = oz + k;
            end
            send_node(px, py, pz, rand_coord(), rand_coord(), rand_coord());
        end
        drain_results();
    endtask

    initial
    begin
        rst_n     = 1'b0;
        start     = 1'b0;
        point_x   = '0;
        point_y   = '0;
        point_z   = '0;
        disp_x    = '0;
        disp_y    = '0;
        disp_z    = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_MODE;
        cfg_data  = '0;
        mismatches = 0;
        idle_pct  = 0;
        geom_mode = GEOM_2D;
        org[0] = 0; org[1] = 0; org[2] = 0;
        axis_dir[0] = 0; axis_dir[1] = 0; axis_dir[2] = AXIS_Z_RESET;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset values: 2D, origin zero, axis along z
        send_node(0, 0, 0, 3, 4, 0);
        send_node(7, -7, 0, 1, 1, 0);
        drain_results();

        test_directed_2d();
        test_directed_3d();
        test_directed_axisym();

        // idle phases: none, heavy, light, none
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:       idle_pct = 0;
                1:       idle_pct = 72;
                2:       idle_pct = 15;
                default: idle_pct = 0;
            endcase
            for (int s = 0; s < 5; s++)
                test_random(100);
        end

        drain_results();
        if (mismatches == 0 && radial_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
